// File: hw/rtl/rmap_packet_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RMAP packet checker
// Short forms for clocked implications with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef RMAP_PACKET_CHECKER_CORE_MACROS_SVH
`define RMAP_PACKET_CHECKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and helper functions shared by the RMAP packet checker.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int MIN_HEADER_BYTES = 8;
    localparam int POS_W            = 25;

    localparam logic [7:0] PROTOCOL_ID    = 8'h01;
    localparam logic [7:0] CRC_POLY_REFL  = 8'hE0;

    localparam logic [4:0] HDR_CMD_BASE    = 5'd16;
    localparam logic [4:0] HDR_WRITE_REPLY = 5'd8;
    localparam logic [4:0] HDR_READ_REPLY  = 5'd12;

    // instruction bits 5..2: write, verify, reply, increment
    localparam logic [3:0] CODE_NONE                = 4'd0;
    localparam logic [3:0] CODE_INC_NO_REPLY        = 4'd1;
    localparam logic [3:0] CODE_VERIFY_NO_REPLY     = 4'd4;
    localparam logic [3:0] CODE_VERIFY_INC_NO_REPLY = 4'd5;
    localparam logic [3:0] CODE_VERIFY_REPLY        = 4'd6;
    localparam logic [3:0] CODE_RMW                 = 4'd7;

    typedef enum logic [3:0] {
        ST_OK,
        ST_INCOMPLETE_HDR,
        ST_NOT_PROTOCOL,
        ST_HEADER_CRC,
        ST_UNUSED_TYPE,
        ST_NO_REPLY,
        ST_UNUSED_CODE,
        ST_NO_DATA_FIELD,
        ST_RMW_LENGTH,
        ST_INSUFFICIENT,
        ST_TOO_MUCH,
        ST_DATA_CRC
    } rpc_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } rpc_in_t;

    typedef struct packed {
        rpc_status_t status;
        logic        is_command;
        logic [7:0]  instruction_byte;
        logic [7:0]  key_or_status;
        logic [7:0]  target_address;
        logic [7:0]  initiator_address;
        logic [15:0] transaction_id;
        logic [7:0]  ext_address;
        logic [31:0] memory_address;
        logic [23:0] payload_len;
    } rpc_out_t;

    // running packet state; first/second address swap roles by packet type
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       header_crc;
        logic [7:0]       payload_crc;
        logic [7:0]       instruction;
        logic [7:0]       protocol;
        logic [7:0]       key_or_status;
        logic [7:0]       first_address;
        logic [7:0]       second_address;
        logic [15:0]      transaction_id;
        logic [7:0]       ext_address;
        logic [31:0]      memory_address;
        logic [23:0]      length;
    } rpc_pkt_t;

    // one byte of the reflected CRC-8 (x^8+x^2+x+1)
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [4:0] hdr_bytes(input logic [7:0] instr);
        if (instr[6]) begin
            return HDR_CMD_BASE + {1'b0, instr[1:0], 2'b00};
        end
        else if (instr[5]) begin
            return HDR_WRITE_REPLY;
        end
        else begin
            return HDR_READ_REPLY;
        end
    endfunction

endpackage

// File: hw/rtl/rpc_in_stage.sv
// ----------------------------------------------------------------------------
// rpc_in_stage
// Input register for packet bytes; takes a new word whenever it empties.
// ----------------------------------------------------------------------------
module rpc_in_stage
    import rpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pkt_valid,
    output logic    pkt_ready,
    input  rpc_in_t pkt,
    input  logic    advance,
    output logic    item_valid,
    output rpc_in_t item
);

    logic    valid_reg;
    logic    valid_next;
    rpc_in_t item_reg;

    assign pkt_ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (pkt_valid && pkt_ready) begin
            valid_next = 1'b1;
        end
        else if (advance) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && pkt_ready) begin
            item_reg <= pkt;
        end
    end

endmodule

// File: hw/rtl/rpc_tracker.sv
// ----------------------------------------------------------------------------
// rpc_tracker
// Byte position, field capture and both CRC accumulators of one packet.
// ----------------------------------------------------------------------------
module rpc_tracker
    import rpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  rpc_in_t  item,
    output rpc_pkt_t pkt_view
);

    localparam logic [POS_W-1:0] POS_FIRST_ADDR = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PROTOCOL   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_INSTR      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_KEY        = POS_W'(3);
    localparam logic [POS_W-1:0] POS_RPL_TARGET = POS_W'(4);
    localparam logic [POS_W-1:0] POS_RPL_TID_HI = POS_W'(5);
    localparam logic [POS_W-1:0] POS_RPL_TID_LO = POS_W'(6);
    localparam logic [POS_W-1:0] POS_RPL_LEN_LO = POS_W'(8);
    localparam logic [POS_W-1:0] POS_RPL_LEN_HI = POS_W'(10);

    localparam logic [4:0] CMD_OFF_BASE = 5'd4;
    localparam logic [4:0] REL_INIT     = 5'd0;
    localparam logic [4:0] REL_TID_HI   = 5'd1;
    localparam logic [4:0] REL_TID_LO   = 5'd2;
    localparam logic [4:0] REL_EXT      = 5'd3;
    localparam logic [4:0] REL_ADDR_3   = 5'd4;
    localparam logic [4:0] REL_ADDR_2   = 5'd5;
    localparam logic [4:0] REL_ADDR_1   = 5'd6;
    localparam logic [4:0] REL_ADDR_0   = 5'd7;
    localparam logic [4:0] REL_LAST     = 5'd10;

    rpc_pkt_t         pkt_reg;
    rpc_pkt_t         pkt_next;
    logic [POS_W-1:0] p;
    logic [7:0]       b;
    logic [4:0]       hs;
    logic [4:0]       cmd_off;
    logic [4:0]       rel;
    logic             in_cmd_window;

    assign pkt_view = pkt_next;

    always_comb
    begin
        pkt_next      = pkt_reg;
        p             = pkt_reg.pos;
        b             = item.data_byte;
        hs            = hdr_bytes(pkt_reg.instruction);
        cmd_off       = CMD_OFF_BASE + {1'b0, pkt_reg.instruction[1:0], 2'b00};
        rel           = p[4:0] - cmd_off;
        in_cmd_window = (p[POS_W-1:5] == '0) && (p[4:0] >= cmd_off) && (rel <= REL_LAST);

        if (p == POS_FIRST_ADDR) begin
            pkt_next.first_address = b;
        end
        else if (p == POS_PROTOCOL) begin
            pkt_next.protocol = b;
        end
        else if (p == POS_INSTR) begin
            pkt_next.instruction = b;
        end
        else if (p == POS_KEY) begin
            pkt_next.key_or_status = b;
        end
        else if (pkt_reg.instruction[6]) begin
            if (in_cmd_window) begin
                case (rel)
                    REL_INIT:   pkt_next.second_address         = b;
                    REL_TID_HI: pkt_next.transaction_id[15:8]   = b;
                    REL_TID_LO: pkt_next.transaction_id[7:0]    = b;
                    REL_EXT:    pkt_next.ext_address            = b;
                    REL_ADDR_3: pkt_next.memory_address[31:24]  = b;
                    REL_ADDR_2: pkt_next.memory_address[23:16]  = b;
                    REL_ADDR_1: pkt_next.memory_address[15:8]   = b;
                    REL_ADDR_0: pkt_next.memory_address[7:0]    = b;
                    default:    pkt_next.length = {pkt_reg.length[15:0], b};
                endcase
            end
        end
        else begin
            if (p == POS_RPL_TARGET) begin
                pkt_next.second_address = b;
            end
            else if (p == POS_RPL_TID_HI) begin
                pkt_next.transaction_id[15:8] = b;
            end
            else if (p == POS_RPL_TID_LO) begin
                pkt_next.transaction_id[7:0] = b;
            end
            else if (p >= POS_RPL_LEN_LO && p <= POS_RPL_LEN_HI
                     && !pkt_reg.instruction[5]) begin
                pkt_next.length = {pkt_reg.length[15:0], b};
            end
        end

        // header size is never below 8, so the first three bytes always land here
        if (p < POS_W'(hs)) begin
            pkt_next.header_crc = crc8_step(pkt_reg.header_crc, b);
        end
        else begin
            pkt_next.payload_crc = crc8_step(pkt_reg.payload_crc, b);
        end

        if (p != '1) begin
            pkt_next.pos = p + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pkt_reg <= '0;
        end
        else if (advance) begin
            pkt_reg <= item.last ? '0 : pkt_next;
        end
    end

endmodule

// File: hw/rtl/rpc_out_stage.sv
// ----------------------------------------------------------------------------
// rpc_out_stage
// Packet verdict and decoded fields, held in the result register.
// ----------------------------------------------------------------------------
module rpc_out_stage
    import rpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  rpc_pkt_t pkt_view,
    input  logic     res_ready,
    output logic     res_valid,
    output rpc_out_t res
);

    logic             valid_reg;
    logic             valid_next;
    rpc_out_t         res_reg;
    rpc_out_t         res_next;
    logic             cmd;
    logic             wr;
    logic [3:0]       code;
    logic             rmw;
    logic [4:0]       hs;
    logic [23:0]      len;
    logic [POS_W-1:0] size;
    logic [POS_W-1:0] expect_size;

    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cmd         = pkt_view.instruction[6];
        wr          = pkt_view.instruction[5];
        code        = pkt_view.instruction[5:2];
        rmw         = (code == CODE_RMW);
        hs          = hdr_bytes(pkt_view.instruction);
        len         = (!cmd && wr) ? 24'd0 : pkt_view.length;
        size        = pkt_view.pos;
        expect_size = POS_W'(hs) + POS_W'(len) + POS_W'(1);

        res_next.is_command        = cmd;
        res_next.instruction_byte  = pkt_view.instruction;
        res_next.key_or_status     = pkt_view.key_or_status;
        res_next.target_address    = cmd ? pkt_view.first_address : pkt_view.second_address;
        res_next.initiator_address = cmd ? pkt_view.second_address : pkt_view.first_address;
        res_next.transaction_id    = pkt_view.transaction_id;
        res_next.ext_address       = cmd ? pkt_view.ext_address : 8'd0;
        res_next.memory_address    = cmd ? pkt_view.memory_address : 32'd0;
        res_next.payload_len       = len;

        if (size < POS_W'(MIN_HEADER_BYTES)) begin
            res_next.status = ST_INCOMPLETE_HDR;
        end
        else if (pkt_view.protocol != PROTOCOL_ID) begin
            res_next.status = ST_NOT_PROTOCOL;
        end
        else if (size < POS_W'(hs)) begin
            res_next.status = ST_INCOMPLETE_HDR;
        end
        else if (pkt_view.header_crc != 8'd0) begin
            res_next.status = ST_HEADER_CRC;
        end
        else if (!cmd && pkt_view.instruction[7]) begin
            res_next.status = ST_UNUSED_TYPE;
        end
        else if (!cmd && !code[1]) begin
            res_next.status = ST_NO_REPLY;
        end
        else if (pkt_view.instruction[7]) begin
            res_next.status = ST_UNUSED_TYPE;
        end
        else if (code inside {CODE_NONE, CODE_INC_NO_REPLY, CODE_VERIFY_NO_REPLY,
                              CODE_VERIFY_INC_NO_REPLY, CODE_VERIFY_REPLY}) begin
            res_next.status = ST_UNUSED_CODE;
        end
        else if (!(rmw || (cmd && wr) || (!cmd && !wr))) begin
            res_next.status = ST_NO_DATA_FIELD;
        end
        else if (rmw && cmd && !(len <= 24'd8 && !len[0])) begin
            res_next.status = ST_RMW_LENGTH;
        end
        else if (rmw && !cmd && len > 24'd4) begin
            res_next.status = ST_RMW_LENGTH;
        end
        else if (size < expect_size) begin
            res_next.status = ST_INSUFFICIENT;
        end
        else if (size > expect_size) begin
            res_next.status = ST_TOO_MUCH;
        end
        else if (pkt_view.payload_crc != 8'd0) begin
            res_next.status = ST_DATA_CRC;
        end
        else begin
            res_next.status = ST_OK;
        end
    end

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end
        else if (res_ready) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: hw/rtl/rmap_packet_checker_core.sv
// ----------------------------------------------------------------------------
// rmap_packet_checker_core
// A packet's last byte passes from the input register into the result register.
// Throughput: one packet byte per cycle, sustained while results are taken.
// A result blocks only the last byte of the following packet while unread.
// Reset (rst_n, async, active low) empties both registers and zeroes all
// packet state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rmap_packet_checker_core
    import rpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pkt_valid,
    output logic     pkt_ready,
    input  rpc_in_t  pkt,
    output logic     res_valid,
    input  logic     res_ready,
    output rpc_out_t res
);

    // Datapath: input register -> tracker (capture + CRC) -> verdict -> result
    // register. The tracker's state register updates on the same edge that
    // loads the result, so each byte crosses one short combinational path.

    logic     item_valid;
    rpc_in_t  item;
    logic     advance;
    logic     load;
    rpc_pkt_t pkt_view;

    // A byte moves out of the input register unless it closes a packet and
    // the result register still holds a word nobody has taken.
    assign advance = item_valid && (!item.last || !res_valid || res_ready);
    assign load    = advance && item.last;

    rpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Position counter saturates at all ones; a long packet then reads as
    // too much data unless an earlier check fires.
    rpc_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item),
        .pkt_view (pkt_view)
    );

    // Checks run in fixed priority; the first failing one sets the status.
    rpc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .pkt_view  (pkt_view),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// File: hw/rtl/rpc_port_checker.sv
// ----------------------------------------------------------------------------
// rpc_port_checker
// Port-level assertions for the RMAP packet checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "rmap_packet_checker_core_macros.svh"

module rpc_port_checker
    import rpc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     pkt_valid,
    input logic     pkt_ready,
    input rpc_in_t  pkt,
    input logic     res_valid,
    input logic     res_ready,
    input rpc_out_t res
);

    `RPC_ASSERT_NEXT(a_pkt_hold, clk, rst_n, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt), "input word changed while stalled")
    `RPC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res), "result word changed while stalled")
    `RPC_ASSERT_NOW(a_type_bit, clk, rst_n, res_valid, res.is_command == res.instruction_byte[6], "is_command disagrees with instruction")
    `RPC_ASSERT_NOW(a_reply_no_addr, clk, rst_n, res_valid && !res.is_command, res.ext_address == 8'd0 && res.memory_address == 32'd0, "reply carries address fields")
    `RPC_ASSERT_NOW(a_wr_reply_len, clk, rst_n, res_valid && !res.is_command && res.instruction_byte[5], res.payload_len == 24'd0, "write reply carries a length")

endmodule

bind rmap_packet_checker_core rpc_port_checker u_port_checker (.*);

// File: verif/rpc_verdict_pkg.sv
// ----------------------------------------------------------------------------
// rpc_verdict_pkg
// Scoreboard for the RMAP packet checker: follows each packet byte by byte,
// works out the status word due at its last byte and checks the results
// against it in order.
// ----------------------------------------------------------------------------
package rpc_verdict_pkg;

    import rpc_pkg::*;

    localparam int RMW_CMD_MAX_LEN   = 8;
    localparam int RMW_REPLY_MAX_LEN = 4;

    class packet_verdicts;

        rpc_out_t due[$];
        int       faults;

        logic [POS_W-1:0] pos;
        logic [7:0]       hdr_crc;
        logic [7:0]       dat_crc;
        logic [7:0]       instr;
        logic [7:0]       proto;
        logic [7:0]       key;
        logic [7:0]       addr_first;
        logic [7:0]       addr_second;
        logic [15:0]      tid;
        logic [7:0]       ext_addr;
        logic [31:0]      mem_addr;
        logic [23:0]      len;
        logic [7:0]       crc_lut[256];

        function new();
            logic [7:0] c;
            for (int i = 0; i < 256; i++)
            begin
                c = 8'(i);
                for (int k = 0; k < 8; k++)
                begin
                    c = c[0] ? ((c >> 1) ^ 8'hE0) : (c >> 1);
                end
                crc_lut[i] = c;
            end
            faults = 0;
            clear();
        endfunction

        function void clear();
            pos         = '0;
            hdr_crc     = '0;
            dat_crc     = '0;
            instr       = '0;
            proto       = '0;
            key         = '0;
            addr_first  = '0;
            addr_second = '0;
            tid         = '0;
            ext_addr    = '0;
            mem_addr    = '0;
            len         = '0;
        endfunction

        function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
            return crc_lut[crc ^ b];
        endfunction

        function int hdr_len();
            if (instr[6])
                return int'(HDR_CMD_BASE) + 4 * int'(instr[1:0]);
            return instr[5] ? int'(HDR_WRITE_REPLY) : int'(HDR_READ_REPLY);
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Accepted input word: update the packet state, and on the last byte
        // queue the status word it must produce.
        function void take_byte(rpc_in_t w);
            rpc_out_t    v;
            int          p;
            int          off;
            logic [3:0]  code;
            logic        cmd;
            logic        wr;
            logic        rmw;
            longint      size;
            longint      hs;
            longint      dlen;
            p = int'(pos);
            if (p == 0)
                addr_first = w.data_byte;
            else if (p == 1)
                proto = w.data_byte;
            else if (p == 2)
                instr = w.data_byte;
            else if (p == 3)
                key = w.data_byte;
            else if (instr[6])
            begin
                // command: reply address bytes sit between key and initiator
                off = 4 + 4 * int'(instr[1:0]);
                if (p >= off && p <= off + 10)
                begin
                    case (p - off)
                        0: addr_second     = w.data_byte;
                        1: tid[15:8]       = w.data_byte;
                        2: tid[7:0]        = w.data_byte;
                        3: ext_addr        = w.data_byte;
                        4: mem_addr[31:24] = w.data_byte;
                        5: mem_addr[23:16] = w.data_byte;
                        6: mem_addr[15:8]  = w.data_byte;
                        7: mem_addr[7:0]   = w.data_byte;
                        default: len = {len[15:0], w.data_byte};
                    endcase
                end
            end
            else if (p == 4)
                addr_second = w.data_byte;
            else if (p == 5)
                tid[15:8] = w.data_byte;
            else if (p == 6)
                tid[7:0] = w.data_byte;
            else if (p >= 8 && p <= 10 && !instr[5])
                len = {len[15:0], w.data_byte};

            if (p < 3 || p < hdr_len())
                hdr_crc = crc_byte(hdr_crc, w.data_byte);
            else
                dat_crc = crc_byte(dat_crc, w.data_byte);
            if (~pos != '0)
                pos = pos + 1'b1;

            if (!w.last)
                return;

            code = instr[5:2];
            cmd  = instr[6];
            wr   = instr[5];
            rmw  = (code == CODE_RMW);
            size = longint'(pos);
            hs   = longint'(hdr_len());
            dlen = (!cmd && wr) ? 0 : longint'(len);

            if (size < MIN_HEADER_BYTES)
                v.status = ST_INCOMPLETE_HDR;
            else if (proto != PROTOCOL_ID)
                v.status = ST_NOT_PROTOCOL;
            else if (size < hs)
                v.status = ST_INCOMPLETE_HDR;
            else if (hdr_crc != 8'h00)
                v.status = ST_HEADER_CRC;
            else if (!cmd && instr[7])
                v.status = ST_UNUSED_TYPE;
            else if (!cmd && !code[1])
                v.status = ST_NO_REPLY;
            else if (instr[7])
                v.status = ST_UNUSED_TYPE;
            else if (code inside {CODE_NONE, CODE_INC_NO_REPLY, CODE_VERIFY_NO_REPLY,
                                  CODE_VERIFY_INC_NO_REPLY, CODE_VERIFY_REPLY})
                v.status = ST_UNUSED_CODE;
            else if (!(rmw || (cmd && wr) || (!cmd && !wr)))
                v.status = ST_NO_DATA_FIELD;
            else if (rmw && cmd && !(dlen <= RMW_CMD_MAX_LEN && dlen[0] == 1'b0))
                v.status = ST_RMW_LENGTH;
            else if (rmw && !cmd && dlen > RMW_REPLY_MAX_LEN)
                v.status = ST_RMW_LENGTH;
            else if (size < hs + dlen + 1)
                v.status = ST_INSUFFICIENT;
            else if (size > hs + dlen + 1)
                v.status = ST_TOO_MUCH;
            else if (dat_crc != 8'h00)
                v.status = ST_DATA_CRC;
            else
                v.status = ST_OK;

            v.is_command        = cmd;
            v.instruction_byte  = instr;
            v.key_or_status     = key;
            v.target_address    = cmd ? addr_first : addr_second;
            v.initiator_address = cmd ? addr_second : addr_first;
            v.transaction_id    = tid;
            v.ext_address       = cmd ? ext_addr : 8'h00;
            v.memory_address    = cmd ? mem_addr : 32'h0;
            v.payload_len       = (!cmd && wr) ? 24'h0 : len;
            due.push_back(v);
            clear();
        endfunction

        function void cmp_field(string fld, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fld, want, seen);
                faults++;
            end
        endfunction

        // Accepted result word: compare with the oldest status word due.
        function void match_result(rpc_out_t got);
            rpc_out_t want;
            if (due.size() == 0)
            begin
                $display("%0t: result word with none due, expected none, actual status %0d",
                         $time, got.status);
                faults++;
                return;
            end
            want = due.pop_front();
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("is_command", 32'(want.is_command), 32'(got.is_command));
            cmp_field("instruction_byte", 32'(want.instruction_byte),
                      32'(got.instruction_byte));
            cmp_field("key_or_status", 32'(want.key_or_status), 32'(got.key_or_status));
            cmp_field("target_address", 32'(want.target_address), 32'(got.target_address));
            cmp_field("initiator_address", 32'(want.initiator_address),
                      32'(got.initiator_address));
            cmp_field("transaction_id", 32'(want.transaction_id), 32'(got.transaction_id));
            cmp_field("ext_address", 32'(want.ext_address), 32'(got.ext_address));
            cmp_field("memory_address", want.memory_address, got.memory_address);
            cmp_field("payload_len", 32'(want.payload_len), 32'(got.payload_len));
        endfunction

    endclass

endpackage

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for rmap_packet_checker_core. Packets are built byte by byte
// (commands, replies, mangled and noise frames), sent in bursts with gaps,
// and every status word is checked field by field against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rpc_pkg::*;
    import rpc_verdict_pkg::*;

    localparam int RANDOM_BYTES    = 500;
    localparam int RANDOM_FRAMES   = 20;
    localparam int PAUSE_AT_FRAMES = 15;
    localparam int HOLD_AT_BYTES   = 250;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 10;

    logic     clk;
    logic     rst_n;
    logic     pkt_valid;
    logic     pkt_ready;
    rpc_in_t  pkt;
    logic     res_valid;
    logic     res_ready;
    rpc_out_t res;

    packet_verdicts verdicts;

    // packet under construction, first byte at index 0
    logic [7:0] frame[$];

    int bytes_sent;
    int frames_sent;
    int burst_left;

    rmap_packet_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous ceiling on the length of a correct run.
    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // Assemble a packet in frame: header laid out by packet type, header
    // CRC, then n_data data bytes and the data CRC (no data field when
    // n_data is negative).
    task automatic build_frame(input logic [7:0] instr, input logic [7:0] proto,
                               input logic [23:0] len_field, input int n_data);
        logic [7:0]  crc;
        logic [7:0]  b;
        logic [15:0] tid;
        logic [31:0] maddr;
        frame.delete();
        tid   = 16'($urandom);
        maddr = $urandom;
        if (instr[6])
        begin
            frame.push_back(rnd8());            // target
            frame.push_back(proto);
            frame.push_back(instr);
            frame.push_back(rnd8());            // key
            repeat (4 * int'(instr[1:0])) frame.push_back(rnd8());  // reply address
            frame.push_back(rnd8());            // initiator
            frame.push_back(tid[15:8]);
            frame.push_back(tid[7:0]);
            frame.push_back(rnd8());            // extended address
            frame.push_back(maddr[31:24]);
            frame.push_back(maddr[23:16]);
            frame.push_back(maddr[15:8]);
            frame.push_back(maddr[7:0]);
            frame.push_back(len_field[23:16]);
            frame.push_back(len_field[15:8]);
            frame.push_back(len_field[7:0]);
        end
        else
        begin
            frame.push_back(rnd8());            // initiator
            frame.push_back(proto);
            frame.push_back(instr);
            frame.push_back(rnd8());            // status
            frame.push_back(rnd8());            // target
            frame.push_back(tid[15:8]);
            frame.push_back(tid[7:0]);
            if (!instr[5])
            begin
                frame.push_back(rnd8());        // reserved
                frame.push_back(len_field[23:16]);
                frame.push_back(len_field[15:8]);
                frame.push_back(len_field[7:0]);
            end
        end
        crc = 8'h00;
        foreach (frame[i]) crc = verdicts.crc_byte(crc, frame[i]);
        frame.push_back(crc);
        if (n_data >= 0)
        begin
            crc = 8'h00;
            repeat (n_data)
            begin
                b   = rnd8();
                crc = verdicts.crc_byte(crc, b);
                frame.push_back(b);
            end
            frame.push_back(crc);
        end
    endtask

    // Send frame as one word per byte, last marked on the final one. The
    // sender works in bursts; between bursts valid may drop for a random gap.
    // Here valid is only lowered at the start of a gap, so a word that
    // follows straight on keeps valid high with a single assignment.
    task automatic send_frame();
        rpc_in_t w;
        int      gap;
        foreach (frame[i])
        begin
            w.data_byte = frame[i];
            w.last      = (i == frame.size() - 1);
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                if (gap > 0)
                begin
                    pkt_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            pkt_valid <= 1'b1;
            pkt       <= w;
            @(posedge clk);
            while (!pkt_ready) @(posedge clk);
            verdicts.take_byte(w);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    // Result side: check every word taken, then choose ready for the next
    // cycle. Ready follows a mode that is re-chosen at random, and
    // once, some way into the run, it is held low for a long stretch so
    // that a finished packet backs up and the input stalls.
    initial
    begin : result_sink
        int         hold_left;
        int         span;
        int         mode;
        bit         hold_done;
        logic [7:0] pat;
        hold_left = 0;
        span      = 0;
        mode      = 0;
        hold_done = 1'b0;
        pat       = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                verdicts.match_result(res);
            if (!hold_done && bytes_sent >= HOLD_AT_BYTES)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 40);
                pat  = rnd8() | 8'h01;
            end
            else
                span--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= 1'($urandom_range(0, 1));
                    2: res_ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        res_ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  instr;
        logic [7:0]  proto;
        logic [23:0] len;
        logic [1:0]  r;
        int          n_data;
        int          pick;
        int          idx;
        int          cut;

        verdicts    = new();
        bytes_sent  = 0;
        frames_sent = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        pkt_valid   = 1'b0;
        pkt         = '0;
        res_ready   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte packet of all ones, short packet of zeros,
        // wrong protocol, write reply (no data field), clean write command
        // with an empty data field.
        frame = '{8'hFF};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        build_frame(8'h28, 8'h02, 24'h0, -1);
        send_frame();
        build_frame(8'h28, PROTOCOL_ID, 24'h0, -1);
        send_frame();
        build_frame(8'h60, PROTOCOL_ID, 24'h0, 0);
        send_frame();

        // Random: mostly well-formed packets of every kind with random
        // content, some mangled afterwards, a few pure noise frames.
        while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES)
        begin
            r      = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom);
            len    = 24'($urandom_range(0, 12));
            n_data = int'(len);
            proto  = ($urandom_range(0, 19) == 0) ? rnd8() : PROTOCOL_ID;
            pick   = $urandom_range(0, 99);
            if (pick < 5)
            begin
                frame.delete();
                repeat ($urandom_range(1, 20)) frame.push_back(rnd8());
            end
            else
            begin
                if (pick < 32)
                begin
                    // write command, any verify/reply/increment
                    instr = {3'b011, 3'($urandom), r};
                end
                else if (pick < 44)
                begin
                    // read command: no data field, even if bytes follow
                    instr  = {4'b0100, 1'b1, 1'($urandom), r};
                    n_data = ($urandom_range(0, 3) == 0) ? int'(len) : -1;
                end
                else if (pick < 58)
                begin
                    // read-modify-write command, mostly legal lengths
                    instr = {2'b01, 4'b0111, r};
                    if ($urandom_range(0, 3) == 0)
                        len = 24'($urandom_range(0, 10));
                    else
                        len = 24'(2 * $urandom_range(0, 4));
                    n_data = int'(len);
                end
                else if (pick < 68)
                begin
                    // write reply
                    instr  = {3'b001, 1'($urandom), 1'b1, 1'($urandom), 2'($urandom)};
                    n_data = ($urandom_range(0, 3) == 0) ? int'(len) : -1;
                end
                else if (pick < 84)
                begin
                    // read or read-modify-write reply
                    if ($urandom_range(0, 1) == 0)
                        instr = {2'b00, 4'b0111, 2'($urandom)};
                    else
                        instr = {5'b00001, 1'($urandom), 2'($urandom)};
                    len    = 24'($urandom_range(0, 6));
                    n_data = int'(len);
                end
                else
                begin
                    // anything at all in the instruction, length may be huge
                    instr = rnd8();
                    if ($urandom_range(0, 1) == 0)
                        len = 24'($urandom);
                    n_data = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 8);
                end
                build_frame(instr, proto, len, n_data);

                case ($urandom_range(0, 11))
                    0, 1:
                    begin
                        // flip a bit in one of the first 16 bytes, all header in a command
                        idx = $urandom_range(0, (frame.size() < 16 ? frame.size() : 16) - 1);
                        frame[idx] ^= 8'(1 << $urandom_range(0, 7));
                    end
                    2:
                    begin
                        idx = $urandom_range(0, frame.size() - 1);
                        frame[idx] ^= 8'(1 << $urandom_range(0, 7));
                    end
                    3:
                    begin
                        repeat ($urandom_range(1, 3))
                            if (frame.size() > 1)
                                void'(frame.pop_back());
                    end
                    4:
                    begin
                        repeat ($urandom_range(1, 3)) frame.push_back(rnd8());
                    end
                    5:
                    begin
                        cut = $urandom_range(1, frame.size());
                        while (frame.size() > cut) void'(frame.pop_back());
                    end
                    default:
                    begin
                    end
                endcase
            end
            send_frame();

            // Once mid-run, stop offering words until every status word
            // due has been taken.
            if (frames_sent == PAUSE_AT_FRAMES)
            begin
                pkt_valid <= 1'b0;
                burst_left = 0;
                while (verdicts.pending() != 0) @(posedge clk);
            end
        end

        pkt_valid <= 1'b0;
        while (verdicts.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdicts.faults == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: rmap_packet_checker_core.f
+incdir+hw/rtl
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_in_stage.sv
hw/rtl/rpc_tracker.sv
hw/rtl/rpc_out_stage.sv
hw/rtl/rmap_packet_checker_core.sv
hw/rtl/rpc_port_checker.sv
verif/rpc_verdict_pkg.sv
verif/tb.sv
